@@ rtl/core/plist_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types of the positional list.
package plist_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int VALUE_W    = 32;
    localparam int POS_W      = 5;
    localparam int EPOS_W     = 4;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_DN,
        RD_PTR_UP,
        RD_POS
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT,
        WR_NEW
    } wr_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_COUNT,
        PTR_POS,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef struct packed {
        logic                capture;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        wr_sel_t             wr_sel;
        ptr_op_t             ptr_op;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                removed_cap;
        logic                out_load;
        logic                out_dump;
        logic                out_removed;
        logic [STATUS_W-1:0] out_status;
    } plist_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              ins_bad;
        logic              del_bad;
        logic              full;
        logic              empty;
        logic              at_pos;
        logic              del_more;
        logic              dump_last;
        logic              out_free;
    } plist_sts_t;

endpackage

@@ rtl/core/plist_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the positional list: request registers, entry memory, count, pointer, result register.
module plist_datapath #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [plist_pkg::MODE_W-1:0]          in_mode,
    input  logic [plist_pkg::POS_W-1:0]           in_pos,
    input  logic signed [plist_pkg::VALUE_W-1:0]  in_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [plist_pkg::STATUS_W-1:0]        out_status,
    output logic signed [plist_pkg::VALUE_W-1:0]  out_value,
    output logic [plist_pkg::EPOS_W-1:0]          out_epos,
    output logic                                  out_last,
    input  plist_pkg::plist_cmd_t                 cmd,
    output plist_pkg::plist_sts_t                 sts
);
    import plist_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [MODE_W-1:0]         mode_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [AW-1:0]             ptr_reg;
    logic [AW-1:0]             ptr_next;
    logic [VALUE_W-1:0]        mem [CAPACITY];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [EPOS_W-1:0]         out_epos_reg;
    logic                      out_last_reg;

    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          count_ext;
    logic [CMP_W-1:0]          ptr_ext;
    logic [CMP_W-1:0]          ptr_inc;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic [VALUE_W-1:0]        wr_data;
    logic                      out_free;

    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign ptr_ext   = CMP_W'(ptr_reg);
    assign ptr_inc   = ptr_ext + CMP_W'(1);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.mode      = mode_reg;
        sts.ins_bad   = pos_ext > count_ext;
        sts.del_bad   = pos_ext >= count_ext;
        sts.full      = count_ext == CMP_W'(CAPACITY);
        sts.empty     = count_reg == '0;
        sts.at_pos    = ptr_ext == pos_ext;
        sts.del_more  = ptr_inc < count_ext;
        // A dump stops at the end of the list or after the largest run it may emit.
        sts.dump_last = (ptr_inc == count_ext) || (ptr_inc == CMP_W'(MAX_RESULTS));
        sts.out_free  = out_free;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_PTR:    rd_addr = ptr_reg;
            RD_PTR_DN: rd_addr = ptr_reg - AW'(1);
            RD_PTR_UP: rd_addr = ptr_reg + AW'(1);
            RD_POS:    rd_addr = pos_ext[AW-1:0];
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
            WR_NEW:
            begin
                wr_addr = pos_ext[AW-1:0];
                wr_data = value_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD:  ptr_next = ptr_reg;
            PTR_COUNT: ptr_next = count_ext[AW-1:0];
            PTR_POS:   ptr_next = pos_ext[AW-1:0];
            PTR_ZERO:  ptr_next = '0;
            PTR_INC:   ptr_next = ptr_reg + AW'(1);
            PTR_DEC:   ptr_next = ptr_reg - AW'(1);
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        priority if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_mode;
            pos_reg   <= in_pos;
            value_reg <= in_value;
        end
        if (cmd.removed_cap)
        begin
            removed_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_value_reg  <= cmd.out_dump ? rd_data_reg
                            : (cmd.out_removed ? removed_reg : '0);
            out_epos_reg   <= cmd.out_dump ? ptr_ext[EPOS_W-1:0] : '0;
            out_last_reg   <= cmd.out_dump ? sts.dump_last : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_epos   = out_epos_reg;
    assign out_last   = out_last_reg;

endmodule

@@ rtl/core/plist_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the positional list: decodes a request and sequences the shifts.
module plist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  plist_pkg::plist_sts_t sts,
    output plist_pkg::plist_cmd_t cmd
);
    import plist_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_ISH_RD   = 4'd2;
    localparam logic [3:0] S_ISH_WR   = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_CAP  = 4'd5;
    localparam logic [3:0] S_DSH_RD   = 4'd6;
    localparam logic [3:0] S_DSH_WR   = 4'd7;
    localparam logic [3:0] S_DUMP_RD  = 4'd8;
    localparam logic [3:0] S_DUMP_OUT = 4'd9;
    localparam logic [3:0] S_RESULT   = 4'd10;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic                res_removed_reg;
    logic                res_removed_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        cmd              = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_removed_next = 1'b0;
                unique case (sts.mode)
                    MODE_INSERT:
                    begin
                        priority if (sts.ins_bad)
                        begin
                            res_status_next = ST_BADPOS;
                            state_next      = S_RESULT;
                        end
                        else if (sts.full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_COUNT;
                            state_next = S_ISH_RD;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (sts.del_bad)
                        begin
                            res_status_next = ST_BADPOS;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_POS;
                            state_next = S_DEL_RD;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (sts.empty)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_DUMP_RD;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_BADPOS;
                        state_next      = S_RESULT;
                    end
                endcase
            end
            // Insert walks the pointer down from the count, moving each entry up one place.
            S_ISH_RD:
            begin
                if (sts.at_pos)
                begin
                    cmd.wr_en        = 1'b1;
                    cmd.wr_sel       = WR_NEW;
                    cmd.cnt_inc      = 1'b1;
                    res_status_next  = ST_OK;
                    res_removed_next = 1'b0;
                    state_next       = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_DN;
                    state_next = S_ISH_WR;
                end
            end
            S_ISH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.ptr_op = PTR_DEC;
                state_next = S_ISH_RD;
            end
            S_DEL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_POS;
                state_next = S_DEL_CAP;
            end
            S_DEL_CAP:
            begin
                cmd.removed_cap = 1'b1;
                state_next      = S_DSH_RD;
            end
            // Delete walks the pointer up from the position, moving each entry down one place.
            S_DSH_RD:
            begin
                if (sts.del_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_UP;
                    state_next = S_DSH_WR;
                end
                else
                begin
                    cmd.cnt_dec      = 1'b1;
                    res_status_next  = ST_OK;
                    res_removed_next = 1'b1;
                    state_next       = S_RESULT;
                end
            end
            S_DSH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.ptr_op = PTR_INC;
                state_next = S_DSH_RD;
            end
            S_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PTR;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_dump   = 1'b1;
                    cmd.out_status = ST_OK;
                    if (sts.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_INC;
                        state_next = S_DUMP_RD;
                    end
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = res_status_reg;
                    cmd.out_removed = res_removed_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            res_status_reg  <= ST_OK;
            res_removed_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            res_status_reg  <= res_status_next;
            res_removed_reg <= res_removed_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while the result register is still held");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded in the next cycle");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !sts.full)
        else $error("count incremented on a full list");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !sts.empty)
        else $error("count decremented on an empty list");

endmodule

@@ rtl/core/positional_list_insert_delete_unit.sv @@
`timescale 1ns / 1ps
// Positional list top level: ordered list of signed values with insert, delete and dump by index.
// Errors go straight to the result; insert moves each entry from the count down to the position up one place,
// delete captures the entry, then moves the ones above it down; dump emits each entry in turn.
// One request at a time: the entry memory has one write and one read port, each move a read then a write.
// Reset clears the count and the control state; entry contents are undefined until written.
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [plist_pkg::IN_DATA_W-1:0]      s_tdata,  // position[4:0], value_in[36:5]
    input  logic [plist_pkg::MODE_W-1:0]         s_tuser,  // mode[1:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [plist_pkg::OUT_DATA_W-1:0]     m_tdata,  // value_out[31:0], entry_position[35:32]
    output logic [plist_pkg::STATUS_W-1:0]       m_tuser,  // status[1:0]
    output logic                                 m_tlast   // last
);
    import plist_pkg::*;

    plist_cmd_t                cmd;
    plist_sts_t                sts;
    logic [POS_W-1:0]          in_pos;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [VALUE_W-1:0] out_value;
    logic [EPOS_W-1:0]         out_epos;

    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign m_tdata  = {(OUT_DATA_W - VALUE_W - EPOS_W)'(0), out_epos, out_value};

    plist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plist_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mode    (s_tuser),
        .in_pos     (in_pos),
        .in_value   (in_value),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_value  (out_value),
        .out_epos   (out_epos),
        .out_last   (m_tlast),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

@@ test/positional_list_insert_delete_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the positional list: directed table, random requests, scoreboard.
module positional_list_insert_delete_unit_tb;

    import plist_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    // The fourth mode code has no operation behind it and must be rejected.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [EPOS_W-1:0]   epos;
        logic                last;
    } list_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  value;
        logic [4:0]          reps;
        logic                typed;
        logic [STATUS_W-1:0] exp_status;
        logic [VALUE_W-1:0]  exp_value;
    } table_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    logic [VALUE_W-1:0] list_values [CAP];
    int unsigned        list_count;
    list_result_t       predicted[$];
    list_result_t       expected_results[$];
    table_row_t         stim_table[$];
    int                 mismatch_count;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;

    positional_list_insert_delete_unit #(
        .CAPACITY(CAP)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_result_t make_result(input logic [STATUS_W-1:0] status,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [EPOS_W-1:0] epos,
                                                 input logic last);
        list_result_t r;
        r.status = status;
        r.value  = value;
        r.epos   = epos;
        r.last   = last;
        return r;
    endfunction

    // Updates the list copy and leaves the results of one request in predicted.
    function automatic void predict_list_op(input logic [MODE_W-1:0] mode,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] removed;
        int unsigned        n;
        predicted.delete();
        case (mode)
            MODE_INSERT:
            begin
                if (pos > list_count)
                    predicted.push_back(make_result(ST_BADPOS, '0, '0, 1'b1));
                else if (list_count >= CAP)
                    predicted.push_back(make_result(ST_FULL, '0, '0, 1'b1));
                else
                begin
                    for (int i = list_count; i > pos; i--)
                        list_values[i] = list_values[i-1];
                    list_values[pos] = value;
                    list_count++;
                    predicted.push_back(make_result(ST_OK, '0, '0, 1'b1));
                end
            end
            MODE_DELETE:
            begin
                if (pos >= list_count)
                    predicted.push_back(make_result(ST_BADPOS, '0, '0, 1'b1));
                else
                begin
                    removed = list_values[pos];
                    for (int i = pos; i + 1 < list_count; i++)
                        list_values[i] = list_values[i+1];
                    list_count--;
                    predicted.push_back(make_result(ST_OK, removed, '0, 1'b1));
                end
            end
            MODE_DUMP:
            begin
                n = (list_count > MAX_RESULTS) ? MAX_RESULTS : list_count;
                if (n == 0)
                    predicted.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                for (int i = 0; i < n; i++)
                    predicted.push_back(make_result(ST_OK, list_values[i], i[EPOS_W-1:0],
                                                    (i + 1 == n)));
            end
            default:
                predicted.push_back(make_result(ST_BADPOS, '0, '0, 1'b1));
        endcase
    endfunction

    function automatic void add_row(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                    input logic [VALUE_W-1:0] value, input int reps,
                                    input logic typed, input logic [STATUS_W-1:0] exp_status,
                                    input logic [VALUE_W-1:0] exp_value);
        table_row_t row;
        row.mode       = mode;
        row.pos        = pos;
        row.value      = value;
        row.reps       = reps[4:0];
        row.typed      = typed;
        row.exp_status = exp_status;
        row.exp_value  = exp_value;
        stim_table.push_back(row);
    endfunction

    // Drives one request, waits for it to be taken, then queues what it should produce.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] value, input logic typed,
                                input logic [STATUS_W-1:0] exp_status,
                                input logic [VALUE_W-1:0] exp_value);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, value, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_list_op(mode, pos, value);
        if (typed)
            expected_results.push_back(make_result(exp_status, exp_value, '0, 1'b1));
        else
            foreach (predicted[i])
                expected_results.push_back(predicted[i]);
    endtask

    function automatic void note_mismatch(input string what, input list_result_t exp_r,
                                          input list_result_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected status %0d value %h pos %0d last %0d",
                     $realtime, what, exp_r.status, exp_r.value, exp_r.epos, exp_r.last);
            $display("%0t: %s: got      status %0d value %h pos %0d last %0d",
                     $realtime, what, got_r.status, got_r.value, got_r.epos, got_r.last);
        end
    endfunction

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        list_result_t got_r;
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r = make_result(m_tuser, m_tdata[31:0], m_tdata[35:32], m_tlast);
            if (expected_results.size() == 0)
                note_mismatch("unexpected result", '0, got_r);
            else
            begin
                exp_r = expected_results.pop_front();
                if (got_r.status !== exp_r.status || got_r.value !== exp_r.value ||
                    got_r.epos !== exp_r.epos || got_r.last !== exp_r.last)
                    note_mismatch("result mismatch", exp_r, got_r);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        table_row_t         row;
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        int                 fill_target;
        int                 r;

        mismatch_count     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        list_count         = 0;
        fill_target        = 0;

        //      mode         pos  value         reps typed status     expected value
        add_row(MODE_DUMP,   0,  32'h0,        1,   1,    ST_EMPTY,  32'h0);
        add_row(MODE_DELETE, 0,  32'h0,        1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_INSERT, 1,  32'h1234,     1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_UNUSED, 31, 32'hFFFFFFFF, 1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_INSERT, 0,  32'h7FFFFFFF, 1,   1,    ST_OK,     32'h0);
        add_row(MODE_INSERT, 0,  32'h80000000, 1,   1,    ST_OK,     32'h0);
        add_row(MODE_INSERT, 2,  32'hFFFFFFFF, 1,   1,    ST_OK,     32'h0);
        add_row(MODE_DUMP,   0,  32'h0,        1,   0,    ST_OK,     32'h0);
        add_row(MODE_DELETE, 1,  32'h0,        1,   1,    ST_OK,     32'h7FFFFFFF);
        add_row(MODE_INSERT, 31, 32'h0,        1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_DELETE, 31, 32'h0,        1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_DELETE, 2,  32'h0,        1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_INSERT, 0,  32'h00C0FFEE, 14,  0,    ST_OK,     32'h0);
        add_row(MODE_INSERT, 0,  32'h0,        1,   1,    ST_FULL,   32'h0);
        add_row(MODE_INSERT, 16, 32'h0,        1,   1,    ST_FULL,   32'h0);
        add_row(MODE_INSERT, 17, 32'h0,        1,   1,    ST_BADPOS, 32'h0);
        add_row(MODE_DUMP,   0,  32'h0,        1,   0,    ST_OK,     32'h0);
        add_row(MODE_DELETE, 15, 32'h0,        1,   1,    ST_OK,     32'hFFFFFFFF);
        add_row(MODE_DELETE, 0,  32'h0,        1,   0,    ST_OK,     32'h0);
        add_row(MODE_DELETE, 0,  32'h0,        14,  0,    ST_OK,     32'h0);
        add_row(MODE_DUMP,   0,  32'h0,        1,   1,    ST_EMPTY,  32'h0);
        add_row(MODE_INSERT, 0,  32'h5A5A5A5A, 1,   1,    ST_OK,     32'h0);
        add_row(MODE_DELETE, 0,  32'h0,        1,   1,    ST_OK,     32'h5A5A5A5A);
        add_row(MODE_DELETE, 0,  32'h0,        1,   1,    ST_BADPOS, 32'h0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[k])
        begin
            row = stim_table[k];
            for (int j = 0; j < row.reps; j++)
                send_request(row.mode, row.pos, row.value + j, row.typed, row.exp_status,
                             row.exp_value);
        end

        // Random traffic: the fill target wanders so that the list runs both empty and full.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
            endcase
            for (int k = 0; k < 80; k++)
            begin
                if (k % 31 == 0)
                    fill_target = $urandom_range(0, CAP);
                r = $urandom_range(0, 99);
                if (r < 3)
                    mode = MODE_UNUSED;
                else if (r < 13)
                    mode = MODE_DUMP;
                else if (list_count < fill_target || (list_count == fill_target && r[0]))
                    mode = MODE_INSERT;
                else
                    mode = MODE_DELETE;

                if ($urandom_range(0, 99) < 88 && mode == MODE_INSERT)
                    pos = POS_W'($urandom_range(0, list_count));
                else if ($urandom_range(0, 99) < 88 && mode == MODE_DELETE && list_count > 0)
                    pos = POS_W'($urandom_range(0, list_count - 1));
                else
                    pos = POS_W'($urandom_range(0, 31));

                case ($urandom_range(0, 9))
                    0: value = 32'h80000000;
                    1: value = 32'h7FFFFFFF;
                    2: value = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'h0;
                    default: value = $urandom;
                endcase
                send_request(mode, pos, value, 1'b0, ST_OK, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/plist_pkg.sv
rtl/core/plist_datapath.sv
rtl/core/plist_ctrl.sv
rtl/core/positional_list_insert_delete_unit.sv
test/positional_list_insert_delete_unit_tb.sv
